// ===== design/impulse_collision_resolver_2d_core_defines.svh =====
// Assertion macros for the impulse collision resolver.
// Included by the port checker; needs no package.
`ifndef IMPULSE_COLLISION_RESOLVER_2D_CORE_DEFINES_SVH
`define IMPULSE_COLLISION_RESOLVER_2D_CORE_DEFINES_SVH

// same-cycle implication
`define ICR2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("icr2d: port check failed");

// next-cycle implication
`define ICR2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("icr2d: port check failed");

`endif

// ===== design/icr2d_pkg.sv =====
// Shared widths, field offsets, types and constants of the collision resolver.
// No dependencies.
`timescale 1ns / 1ps

package icr2d_pkg;

	localparam int VEL_W     = 32;
	localparam int IM_W      = 32;
	localparam int BOUNCE_W  = 17;
	localparam int NORM_W    = 16;
	localparam int NORM_FRAC = 14;
	localparam int MASS_FRAC = 16;

	// input word offsets
	localparam int OFF_V1X = 0;
	localparam int OFF_V1Y = OFF_V1X + VEL_W;
	localparam int OFF_V2X = OFF_V1Y + VEL_W;
	localparam int OFF_V2Y = OFF_V2X + VEL_W;
	localparam int OFF_IM1 = OFF_V2Y + VEL_W;
	localparam int OFF_IM2 = OFF_IM1 + IM_W;
	localparam int OFF_B1  = OFF_IM2 + IM_W;
	localparam int OFF_B2  = OFF_B1 + BOUNCE_W;
	localparam int OFF_NX  = OFF_B2 + BOUNCE_W;
	localparam int OFF_NY  = OFF_NX + NORM_W;
	localparam int IN_BITS = OFF_NY + NORM_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = 4 * VEL_W;
	localparam int OUT_USER_W = 2;

	localparam logic [BOUNCE_W-1:0] ONE_BOUNCE = {1'b1, {(BOUNCE_W-1){1'b0}}};

	// internal widths
	localparam int DIFF_W   = VEL_W + 1;
	localparam int PROD_W   = DIFF_W + NORM_W;
	localparam int VN_W     = PROD_W + 1;
	localparam int A_W      = VN_W - 1;
	localparam int EP_W     = BOUNCE_W + 1;
	localparam int A_LO_W   = 25;
	localparam int A_HI_W   = A_W - A_LO_W;
	localparam int PPN_LO_W = EP_W + A_LO_W;
	localparam int PPN_HI_W = EP_W + A_HI_W;
	localparam int NUM_W    = 66;
	localparam int IMS_W    = IM_W + 1;
	localparam int REM_W    = IMS_W + NORM_FRAC;
	localparam int Q_W      = 52;
	localparam int DIV_STEPS = Q_W;
	localparam int MN_W     = IM_W + NORM_W;
	localparam int MN_LO_W  = MN_W / 2;
	localparam int Q_LO_W   = Q_W / 2;
	localparam int PP_W     = (MN_W - MN_LO_W) + (Q_W - Q_LO_W);
	localparam int P_W      = MN_W + Q_W;
	localparam int SHIFT    = NORM_FRAC + MASS_FRAC;
	localparam int MAG_W    = 35;
	localparam int SUM_W    = MAG_W + 1;
	localparam int TAIL_STAGES = 4;

	localparam logic [MAG_W-1:0] DELTA_CAP = {1'b1, {(MAG_W-1){1'b0}}};

	typedef enum logic [OUT_USER_W-1:0] {
		OUT_SEPARATE  = 2'd0,
		OUT_IMPULSE   = 2'd1,
		OUT_IMMOVABLE = 2'd2
	} outcome_t;

	// one velocity component: value, inverse mass times |normal|, add or subtract
	typedef struct packed {
		logic signed [VEL_W-1:0] vel;
		logic [MN_W-1:0]         mn;
		logic                    add;
	} lane_t;

	typedef struct packed {
		lane_t [3:0] lane;
		outcome_t    outcome;
	} side_t;

endpackage

// ===== design/impulse_collision_resolver_2d_core.sv =====
// Impulse collision resolver, 2D, one contact per input word.
// Input channel s_*: both bodies' velocities, inverse masses, restitutions and
// the contact normal. Output channel m_*: the four resolved velocity components
// in m_tdata and the outcome code in m_tuser.
// Pipeline: 5 front stages for normal velocity and impulse numerator, 52
// divider stages at one quotient bit each, 4 stages to weight, scale and
// saturate the velocity changes. Throughput: one word per cycle while the
// output does not stall; every stage is a single register level.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// Stall: while the output word waits, the whole pipeline holds and s_tready
// drops in the same cycle; nothing is dropped or repeated.
// Depends on icr2d_pkg, icr2d_div, icr2d_lane.
`timescale 1ns / 1ps

module impulse_collision_resolver_2d_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// first_vel_x, first_vel_y, second_vel_x, second_vel_y, first_inv_mass,
	// second_inv_mass, first_bounce, second_bounce, normal_x, normal_y, zero pad
	input  logic [icr2d_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
	output logic [icr2d_pkg::OUT_DATA_W-1:0]    m_tdata,
	// outcome
	output logic [icr2d_pkg::OUT_USER_W-1:0]    m_tuser
);
	import icr2d_pkg::*;

	logic en;

	logic signed [VEL_W-1:0]  in_v1x, in_v1y, in_v2x, in_v2y;
	logic [IM_W-1:0]          in_im1, in_im2;
	logic [BOUNCE_W-1:0]      in_b1, in_b2, b1c, b2c;
	logic signed [NORM_W-1:0] in_nx, in_ny;

	logic                     vld_s1;
	logic signed [VEL_W-1:0]  v1x_s1, v1y_s1, v2x_s1, v2y_s1;
	logic signed [DIFF_W-1:0] rx_s1, ry_s1;
	logic signed [NORM_W-1:0] nx_s1, ny_s1;
	logic [IM_W-1:0]          im1_s1, im2_s1;
	logic [IMS_W-1:0]         ims_s1;
	logic [BOUNCE_W-1:0]      e_s1;

	logic [NORM_W-1:0]        anx, any;
	logic                     vld_s2;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic [IMS_W-1:0]         ims_s2;
	logic [BOUNCE_W-1:0]      e_s2;
	lane_t [3:0]              lane_s2;

	logic signed [VN_W-1:0]   na;
	logic                     vld_s3;
	logic [A_W-1:0]           a_s3;
	logic [EP_W-1:0]          ep_s3;
	logic [IMS_W-1:0]         ims_s3;
	side_t                    side_s3;

	logic                     vld_s4;
	logic [PPN_LO_W-1:0]      pp_lo_s4;
	logic [PPN_HI_W-1:0]      pp_hi_s4;
	logic [IMS_W-1:0]         ims_s4;
	side_t                    side_s4;

	logic                     vld_s5;
	logic [NUM_W-1:0]         num_s5;
	logic [IMS_W-1:0]         ims_s5;
	side_t                    side_s5;

	logic                     div_vld;
	logic [Q_W-1:0]           div_q;
	side_t                    div_side;
	logic                     div_apply;

	logic [TAIL_STAGES-1:0]   tail_vld_s;
	outcome_t                 tail_out_s [TAIL_STAGES];
	logic signed [VEL_W-1:0]  lane_vel [4];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign in_v1x = s_tdata[OFF_V1X +: VEL_W];
	assign in_v1y = s_tdata[OFF_V1Y +: VEL_W];
	assign in_v2x = s_tdata[OFF_V2X +: VEL_W];
	assign in_v2y = s_tdata[OFF_V2Y +: VEL_W];
	assign in_im1 = s_tdata[OFF_IM1 +: IM_W];
	assign in_im2 = s_tdata[OFF_IM2 +: IM_W];
	assign in_b1  = s_tdata[OFF_B1 +: BOUNCE_W];
	assign in_b2  = s_tdata[OFF_B2 +: BOUNCE_W];
	assign in_nx  = s_tdata[OFF_NX +: NORM_W];
	assign in_ny  = s_tdata[OFF_NY +: NORM_W];

	// restitution above 1.0 clamps to 1.0
	assign b1c = (in_b1 > ONE_BOUNCE) ? ONE_BOUNCE : in_b1;
	assign b2c = (in_b2 > ONE_BOUNCE) ? ONE_BOUNCE : in_b2;

	// valid chain of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// s1: relative velocity, lesser restitution, mass sum
	always_ff @(posedge clk) begin
		if (en) begin
			v1x_s1 <= in_v1x;
			v1y_s1 <= in_v1y;
			v2x_s1 <= in_v2x;
			v2y_s1 <= in_v2y;
			rx_s1  <= DIFF_W'(in_v2x) - DIFF_W'(in_v1x);
			ry_s1  <= DIFF_W'(in_v2y) - DIFF_W'(in_v1y);
			nx_s1  <= in_nx;
			ny_s1  <= in_ny;
			im1_s1 <= in_im1;
			im2_s1 <= in_im2;
			ims_s1 <= IMS_W'(in_im1) + IMS_W'(in_im2);
			e_s1   <= (b1c < b2c) ? b1c : b2c;
		end
	end

	// s2: normal products, mass weights per component
	assign anx = nx_s1[NORM_W-1] ? NORM_W'(-nx_s1) : NORM_W'(nx_s1);
	assign any = ny_s1[NORM_W-1] ? NORM_W'(-ny_s1) : NORM_W'(ny_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2  <= PROD_W'(rx_s1) * PROD_W'(nx_s1);
			py_s2  <= PROD_W'(ry_s1) * PROD_W'(ny_s1);
			ims_s2 <= ims_s1;
			e_s2   <= e_s1;
			lane_s2[0].vel <= v1x_s1;
			lane_s2[0].mn  <= MN_W'(im1_s1) * MN_W'(anx);
			lane_s2[0].add <= nx_s1[NORM_W-1];
			lane_s2[1].vel <= v1y_s1;
			lane_s2[1].mn  <= MN_W'(im1_s1) * MN_W'(any);
			lane_s2[1].add <= ny_s1[NORM_W-1];
			lane_s2[2].vel <= v2x_s1;
			lane_s2[2].mn  <= MN_W'(im2_s1) * MN_W'(anx);
			lane_s2[2].add <= !nx_s1[NORM_W-1];
			lane_s2[3].vel <= v2y_s1;
			lane_s2[3].mn  <= MN_W'(im2_s1) * MN_W'(any);
			lane_s2[3].add <= !ny_s1[NORM_W-1];
		end
	end

	// s3: negated normal velocity and outcome; separating when it is negative
	assign na = -(VN_W'(px_s2) + VN_W'(py_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= na[A_W-1:0];
			ep_s3  <= EP_W'(ONE_BOUNCE) + EP_W'(e_s2);
			ims_s3 <= ims_s2;
			side_s3.lane <= lane_s2;
			priority if (na[VN_W-1]) begin
				side_s3.outcome <= OUT_SEPARATE;
			end else if (ims_s2 == '0) begin
				side_s3.outcome <= OUT_IMMOVABLE;
			end else begin
				side_s3.outcome <= OUT_IMPULSE;
			end
		end
	end

	// s4, s5: numerator (1+e) * -vn
	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s4 <= PPN_LO_W'(ep_s3) * PPN_LO_W'(a_s3[A_LO_W-1:0]);
			pp_hi_s4 <= PPN_HI_W'(ep_s3) * PPN_HI_W'(a_s3[A_W-1:A_LO_W]);
			ims_s4   <= ims_s3;
			side_s4  <= side_s3;
			num_s5   <= NUM_W'(pp_lo_s4) + (NUM_W'(pp_hi_s4) << A_LO_W);
			ims_s5   <= ims_s4;
			side_s5  <= side_s4;
		end
	end

	icr2d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.num      (num_s5),
		.ims      (ims_s5),
		.in_side  (side_s5),
		.out_vld  (div_vld),
		.quot     (div_q),
		.out_side (div_side)
	);

	assign div_apply = div_side.outcome == OUT_IMPULSE;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		icr2d_lane u_lane (
			.clk     (clk),
			.en      (en),
			.quot    (div_q),
			.lane_in (div_side.lane[i]),
			.apply   (div_apply),
			.vel     (lane_vel[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_vld_s <= '0;
		end else if (en) begin
			tail_vld_s <= {tail_vld_s[TAIL_STAGES-2:0], div_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_out_s[0] <= div_side.outcome;
			for (int i = 1; i < TAIL_STAGES; i++) begin
				tail_out_s[i] <= tail_out_s[i-1];
			end
		end
	end

	assign m_tvalid = tail_vld_s[TAIL_STAGES-1];
	assign m_tuser  = tail_out_s[TAIL_STAGES-1];
	assign m_tdata  = {lane_vel[3], lane_vel[2], lane_vel[1], lane_vel[0]};

endmodule

// ===== design/icr2d_div.sv =====
// Pipelined restoring divider for the impulse scalar, one quotient bit per stage.
// Carries the contact sideband alongside; depends on icr2d_pkg.
`timescale 1ns / 1ps

module icr2d_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [icr2d_pkg::NUM_W-1:0]  num,
	input  logic [icr2d_pkg::IMS_W-1:0]  ims,
	input  icr2d_pkg::side_t             in_side,
	output logic                         out_vld,
	output logic [icr2d_pkg::Q_W-1:0]    quot,
	output icr2d_pkg::side_t             out_side
);
	import icr2d_pkg::*;

	logic             vld_s  [DIV_STEPS];
	logic [REM_W-1:0] rem_s  [DIV_STEPS];
	logic [Q_W-1:0]   nq_s   [DIV_STEPS];
	logic [IMS_W-1:0] ims_s  [DIV_STEPS];
	side_t            side_s [DIV_STEPS];

	// nq holds the unused dividend bits on top, the quotient bits shift in below
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic             vld_in;
		logic [REM_W-1:0] rem_in;
		logic [Q_W-1:0]   nq_in;
		logic [IMS_W-1:0] ims_in;
		side_t            side_in;
		logic [REM_W:0]   trial;
		logic [REM_W:0]   dvs;
		logic             fit;

		if (k == 0) begin : g_head
			assign vld_in  = in_vld;
			assign rem_in  = REM_W'(num[NUM_W-1:Q_W]);
			assign nq_in   = num[Q_W-1:0];
			assign ims_in  = ims;
			assign side_in = in_side;
		end else begin : g_body
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign nq_in   = nq_s[k-1];
			assign ims_in  = ims_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = {rem_in, nq_in[Q_W-1]};
		assign dvs   = {1'b0, ims_in, {NORM_FRAC{1'b0}}};
		assign fit   = trial >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fit ? REM_W'(trial - dvs) : REM_W'(trial);
				nq_s[k]   <= {nq_in[Q_W-2:0], fit};
				ims_s[k]  <= ims_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[DIV_STEPS-1];
	assign quot     = nq_s[DIV_STEPS-1];
	assign out_side = side_s[DIV_STEPS-1];

endmodule

// ===== design/icr2d_lane.sv =====
// One velocity component: impulse times mass weight, scale, clamp, apply, saturate.
// Four register stages; depends on icr2d_pkg.
`timescale 1ns / 1ps

module icr2d_lane (
	input  logic                               clk,
	input  logic                               en,
	input  logic [icr2d_pkg::Q_W-1:0]          quot,
	input  icr2d_pkg::lane_t                   lane_in,
	input  logic                               apply,
	output logic signed [icr2d_pkg::VEL_W-1:0] vel
);
	import icr2d_pkg::*;

	localparam int MN_HI_W = MN_W - MN_LO_W;
	localparam int Q_HI_W  = Q_W - Q_LO_W;

	logic [PP_W-1:0]         ll_s1, lh_s1, hl_s1, hh_s1;
	logic signed [VEL_W-1:0] vel_s1, vel_s2, vel_s3;
	logic                    add_s1, add_s2, add_s3;
	logic                    apply_s1, apply_s2;
	logic [P_W-1:0]          p_s2;
	logic [MAG_W-1:0]        mag_s3;

	logic [MN_LO_W-1:0] ml;
	logic [MN_HI_W-1:0] mh;
	logic [Q_LO_W-1:0]  jl;
	logic [Q_HI_W-1:0]  jh;
	logic               over;
	logic signed [SUM_W-1:0] vext, mext, sum;

	assign ml = lane_in.mn[MN_LO_W-1:0];
	assign mh = lane_in.mn[MN_W-1:MN_LO_W];
	assign jl = quot[Q_LO_W-1:0];
	assign jh = quot[Q_W-1:Q_LO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1    <= PP_W'(ml) * PP_W'(jl);
			lh_s1    <= PP_W'(ml) * PP_W'(jh);
			hl_s1    <= PP_W'(mh) * PP_W'(jl);
			hh_s1    <= PP_W'(mh) * PP_W'(jh);
			vel_s1   <= lane_in.vel;
			add_s1   <= lane_in.add;
			apply_s1 <= apply;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= P_W'(ll_s1) + (P_W'(lh_s1) << Q_LO_W) + (P_W'(hl_s1) << MN_LO_W)
				+ (P_W'(hh_s1) << (Q_LO_W + MN_LO_W));
			vel_s2   <= vel_s1;
			add_s2   <= add_s1;
			apply_s2 <= apply_s1;
		end
	end

	assign over = p_s2[P_W-1:SHIFT] > (P_W - SHIFT)'(DELTA_CAP);

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (!apply_s2) begin
				mag_s3 <= '0;
			end else if (over) begin
				mag_s3 <= DELTA_CAP;
			end else begin
				mag_s3 <= p_s2[SHIFT+MAG_W-1:SHIFT];
			end
			vel_s3 <= vel_s2;
			add_s3 <= add_s2;
		end
	end

	assign vext = SUM_W'(vel_s3);
	assign mext = SUM_W'(mag_s3);
	assign sum  = add_s3 ? vext + mext : vext - mext;

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (!sum[SUM_W-1] && (|sum[SUM_W-2:VEL_W-1])) begin
				vel <= {1'b0, {(VEL_W-1){1'b1}}};
			end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:VEL_W-1])) begin
				vel <= {1'b1, {(VEL_W-1){1'b0}}};
			end else begin
				vel <= sum[VEL_W-1:0];
			end
		end
	end

endmodule

// ===== design/icr2d_chk.sv =====
// Port checker for the collision resolver, bound to the top level.
// Depends on icr2d_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "impulse_collision_resolver_2d_core_defines.svh"

module icr2d_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [icr2d_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [icr2d_pkg::OUT_USER_W-1:0] m_tuser
);
	import icr2d_pkg::*;

	logic out_stall;

	assign out_stall = m_tvalid && !m_tready;

	// a waiting output word holds
	`ICR2D_ASSERT_NEXT(a_hold, clk, arst_n, out_stall, m_tvalid && $stable({m_tdata, m_tuser}))
	// a stalled output freezes the whole pipe, so no new word is taken
	`ICR2D_ASSERT_NOW(a_stall_blocks, clk, arst_n, out_stall, !s_tready)
	// an empty output stage never holds off the input
	`ICR2D_ASSERT_NOW(a_empty_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind impulse_collision_resolver_2d_core icr2d_chk u_icr2d_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
